// ----- rtl/zigzag_varint_field_writer_macros.svh -----
// Assertion macros used by the writer RTL file.
`ifndef ZIGZAG_VARINT_FIELD_WRITER_MACROS_SVH
`define ZIGZAG_VARINT_FIELD_WRITER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ZVW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ZVW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/zvw_pkg.sv -----
`default_nettype none

package zvw_pkg;

    localparam int CAP_W   = 17;
    localparam int POS_W   = 16;
    localparam int CNT_W   = 4;
    localparam int VALUE_W = 64;
    localparam int GROUP_W = 7;
    localparam int GROUPS  = 10;

    localparam logic [CAP_W-1:0] RESET_CAPACITY = 17'h10000;
    localparam logic [CAP_W-1:0] CAP_ALL_ONES   = 17'h1FFFF;

    typedef enum logic [2:0] {
        ACT_RAW8  = 3'd0,
        ACT_RAW64 = 3'd1,
        ACT_U16   = 3'd2,
        ACT_S16   = 3'd3,
        ACT_U32   = 3'd4,
        ACT_S32   = 3'd5,
        ACT_U64   = 3'd6,
        ACT_S64   = 3'd7
    } action_t;

    // Controls from the sequencer to the byte shifter.
    typedef struct packed {
        logic load;       // capture a new item and map it
        logic size_load;  // set the number of bytes still to send
        logic step;       // send one byte and shift the word
    } shift_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/zvw_if.sv -----
`default_nettype none

interface zvw_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [63:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface zvw_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [15:0] byte_position;
    logic        last_of_item;
    logic        status;

    modport source (output valid, output out_byte, output byte_position,
                    output last_of_item, output status, input ready);
    modport sink   (input valid, input out_byte, input byte_position,
                    input last_of_item, input status, output ready);
endinterface

interface zvw_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] buffer_capacity;

    modport source (output valid, output buffer_capacity, input ready);
    modport sink   (input valid, input buffer_capacity, output ready);
endinterface

`default_nettype wire

// ----- rtl/zigzag_varint_field_writer.sv -----
// An accepted item is checked for space in ST_CHECK; its bytes then go out from
// ST_EMIT, or a no-space report is registered from ST_CHECK. A new item is taken
// only in ST_IDLE. An item writes N output bytes (N is 1 to 10), one byte per cycle
// from the byte shifter while the output slot is free.
// Results are held in an output register, so a stalled sink pauses the byte shifter.
// Reset: write offset 0, capacity 65536, no item in flight; no clearing pass.
`default_nettype none
`include "zigzag_varint_field_writer_macros.svh"

module zigzag_varint_field_writer #(
    parameter longint unsigned MAX_BUFFER_BYTES = 65536
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    zvw_item_if.sink   items,
    zvw_result_if.source results,
    zvw_cfg_if.sink    cfg
);

    // Capacities above the register range never clamp.
    localparam logic [zvw_pkg::CAP_W-1:0] CapLimit =
        (MAX_BUFFER_BYTES >= 64'(zvw_pkg::CAP_ALL_ONES)) ? zvw_pkg::CAP_ALL_ONES
                                                        : 17'(MAX_BUFFER_BYTES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [zvw_pkg::CAP_W-1:0]   offset_reg, offset_next;
    logic [zvw_pkg::CAP_W-1:0]   cap_reg, cap_next;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_byte_reg, out_byte_next;
    logic [zvw_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                        last_reg, last_next;
    logic                        status_reg, status_next;

    zvw_pkg::shift_ctrl_t        ctrl;
    logic [zvw_pkg::VALUE_W-1:0] shift_word;
    zvw_pkg::action_t            shift_kind;
    logic [7:0]                  shift_byte;
    logic                        shift_last;
    logic [zvw_pkg::CNT_W-1:0]   size;
    logic [zvw_pkg::CAP_W-1:0]   cap_eff;
    logic                        fits;
    logic                        slot_free;

    zvw_shifter u_shifter (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .action    (items.action),
        .value     (items.value),
        .size      (size),
        .word      (shift_word),
        .kind      (shift_kind),
        .data_byte (shift_byte),
        .last      (shift_last)
    );

    zvw_sizer u_sizer (
        .word (shift_word),
        .kind (shift_kind),
        .size (size)
    );

    assign cap_eff   = (cap_reg > CapLimit) ? CapLimit : cap_reg;
    assign fits      = (offset_reg < cap_eff) &&
                       ({{(zvw_pkg::CAP_W-zvw_pkg::CNT_W){1'b0}}, size} <= (cap_eff - offset_reg));
    assign slot_free = !out_valid_reg || results.ready;

    assign items.ready = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        offset_next    = offset_reg;
        cap_next       = cap_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        ctrl           = '0;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg.valid)
        begin
            cap_next = cfg.buffer_capacity;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (items.valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (fits)
                begin
                    ctrl.size_load = 1'b1;
                    state_next     = ST_EMIT;
                end
                else if (slot_free)
                begin
                    // No space: one error result, offset left as it is.
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'h00;
                    pos_next       = offset_reg[zvw_pkg::POS_W-1:0];
                    last_next      = 1'b1;
                    status_next    = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ctrl.step      = 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = shift_byte;
                    pos_next       = offset_reg[zvw_pkg::POS_W-1:0];
                    last_next      = shift_last;
                    status_next    = 1'b0;
                    offset_next    = offset_reg + 17'd1;
                    if (shift_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            offset_reg    <= '0;
            cap_reg       <= zvw_pkg::RESET_CAPACITY;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            pos_reg       <= '0;
            last_reg      <= 1'b0;
            status_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            pos_reg       <= pos_next;
            last_reg      <= last_next;
            status_reg    <= status_next;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.out_byte      = out_byte_reg;
    assign results.byte_position = pos_reg;
    assign results.last_of_item  = last_reg;
    assign results.status        = status_reg;

    `ZVW_ASSERT_NEXT(a_error_keeps_offset, clk, rst_n,
        (state_reg == ST_CHECK) && !fits && slot_free, $stable(offset_reg),
        "error result moved the write offset")
    `ZVW_ASSERT_NEXT(a_byte_advances_offset, clk, rst_n,
        (state_reg == ST_EMIT) && slot_free, offset_reg == $past(offset_reg) + 17'd1,
        "sent byte did not advance the offset")
    `ZVW_ASSERT_IMPL(a_size_in_range, clk, rst_n,
        state_reg == ST_CHECK, (size != 4'd0) && (size <= 4'd10),
        "encoded length out of range")

endmodule

`default_nettype wire

// ----- rtl/zvw_shifter.sv -----
`default_nettype none

module zvw_shifter (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire zvw_pkg::shift_ctrl_t         ctrl,
    input  wire logic [2:0]                   action,
    input  wire logic [zvw_pkg::VALUE_W-1:0]  value,
    input  wire logic [zvw_pkg::CNT_W-1:0]    size,
    output logic [zvw_pkg::VALUE_W-1:0]       word,
    output zvw_pkg::action_t                  kind,
    output logic [7:0]                        data_byte,
    output logic                              last
);

    logic [zvw_pkg::VALUE_W-1:0] word_reg;
    logic [zvw_pkg::VALUE_W-1:0] mapped;
    zvw_pkg::action_t            kind_reg;
    logic [zvw_pkg::CNT_W-1:0]   remain_reg;
    logic                        raw;

    // Zigzag mapping at the width of the kind; unsigned kinds are masked.
    always_comb
    begin
        mapped = '0;
        unique case (zvw_pkg::action_t'(action))
            zvw_pkg::ACT_RAW8,
            zvw_pkg::ACT_RAW64,
            zvw_pkg::ACT_U64:
            begin
                mapped = value;
            end
            zvw_pkg::ACT_U16:
            begin
                mapped = {48'b0, value[15:0]};
            end
            zvw_pkg::ACT_S16:
            begin
                mapped = {48'b0, {value[14:0], 1'b0} ^ {16{value[15]}}};
            end
            zvw_pkg::ACT_U32:
            begin
                mapped = {32'b0, value[31:0]};
            end
            zvw_pkg::ACT_S32:
            begin
                mapped = {32'b0, {value[30:0], 1'b0} ^ {32{value[31]}}};
            end
            zvw_pkg::ACT_S64:
            begin
                mapped = {value[62:0], 1'b0} ^ {64{value[63]}};
            end
        endcase
    end

    assign raw = (kind_reg == zvw_pkg::ACT_RAW8) || (kind_reg == zvw_pkg::ACT_RAW64);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            kind_reg   <= zvw_pkg::ACT_RAW8;
        end
        else
        begin
            if (ctrl.load)
            begin
                kind_reg <= zvw_pkg::action_t'(action);
            end
            if (ctrl.size_load)
            begin
                remain_reg <= size;
            end
            else if (ctrl.step)
            begin
                remain_reg <= remain_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            word_reg <= mapped;
        end
        else if (ctrl.step)
        begin
            word_reg <= raw ? (word_reg >> 8) : (word_reg >> zvw_pkg::GROUP_W);
        end
    end

    // Varint bytes carry the continuation flag while more bytes follow.
    assign data_byte = raw ? word_reg[7:0] : {(remain_reg > 4'd1), word_reg[6:0]};
    assign last      = (remain_reg == 4'd1);
    assign word      = word_reg;
    assign kind      = kind_reg;

endmodule

`default_nettype wire

// ----- rtl/zvw_sizer.sv -----
`default_nettype none

module zvw_sizer (
    input  wire logic [zvw_pkg::VALUE_W-1:0] word,
    input  wire zvw_pkg::action_t            kind,
    output logic [zvw_pkg::CNT_W-1:0]        size
);

    logic [zvw_pkg::GROUPS-1:0] nonzero;
    logic [zvw_pkg::CNT_W-1:0]  groups_used;

    // The varint length follows from the highest 7-bit group that is nonzero.
    always_comb
    begin
        for (int i = 0; i < zvw_pkg::GROUPS - 1; i++)
        begin
            nonzero[i] = |word[zvw_pkg::GROUP_W*i +: zvw_pkg::GROUP_W];
        end
        nonzero[zvw_pkg::GROUPS-1] = word[zvw_pkg::VALUE_W-1];
    end

    always_comb
    begin
        groups_used = 4'd1;
        for (int i = 1; i < zvw_pkg::GROUPS; i++)
        begin
            if (nonzero[i])
            begin
                groups_used = 4'(i + 1);
            end
        end
    end

    always_comb
    begin
        unique case (kind)
            zvw_pkg::ACT_RAW8:  size = 4'd1;
            zvw_pkg::ACT_RAW64: size = 4'd8;
            default:            size = groups_used;
        endcase
    end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUFFER_LIMIT = 65536;
    localparam int QUIET_LIMIT  = 2000;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] byte_position;
        logic        last_of_item;
        logic        status;
    } wr_result_t;

    logic clk;
    logic rst_n;

    zvw_item_if   item_ch ();
    zvw_result_if result_ch ();
    zvw_cfg_if    cfg_ch ();

    zigzag_varint_field_writer #(
        .MAX_BUFFER_BYTES(BUFFER_LIMIT)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (item_ch),
        .results(result_ch),
        .cfg    (cfg_ch)
    );

    // Predicted buffer state and the bytes still owed by the block.
    wr_result_t  pending_bytes[$];
    logic [16:0] model_capacity;
    logic [16:0] model_offset;

    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int errors          = 0;
    int items_sent      = 0;
    int bytes_checked   = 0;
    int no_space_seen   = 0;
    int cfg_writes      = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] zigzag_map(logic [63:0] v, int bits);
        logic [63:0] mask;
        mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
        return ((v << 1) ^ {64{v[bits-1]}}) & mask;
    endfunction

    // Works out the bytes one item writes, or the no-space report, and
    // advances the predicted offset.
    function automatic void encode_field(zvw_pkg::action_t act, logic [63:0] value);
        logic [7:0]  enc [10];
        logic [63:0] word;
        int          n;
        int          cap_eff;
        int          room;
        wr_result_t  r;
        n = 0;
        word = '0;
        case (act)
            zvw_pkg::ACT_RAW8:
            begin
                enc[0] = value[7:0];
                n = 1;
            end
            zvw_pkg::ACT_RAW64:
            begin
                for (int i = 0; i < 8; i++)
                    enc[i] = value[8*i +: 8];
                n = 8;
            end
            default:
            begin
                case (act)
                    zvw_pkg::ACT_U16: word = {48'd0, value[15:0]};
                    zvw_pkg::ACT_S16: word = zigzag_map(value, 16);
                    zvw_pkg::ACT_U32: word = {32'd0, value[31:0]};
                    zvw_pkg::ACT_S32: word = zigzag_map(value, 32);
                    zvw_pkg::ACT_U64: word = value;
                    default:          word = zigzag_map(value, 64);
                endcase
                do
                begin
                    enc[n] = {(word >> 7) != 64'd0, word[6:0]};
                    word = word >> 7;
                    n++;
                end
                while (word != 64'd0);
            end
        endcase

        cap_eff = (int'(model_capacity) > BUFFER_LIMIT) ? BUFFER_LIMIT : int'(model_capacity);
        room = (int'(model_offset) < cap_eff) ? cap_eff - int'(model_offset) : 0;

        if (n > room)
        begin
            r.out_byte      = 8'd0;
            r.byte_position = model_offset[15:0];
            r.last_of_item  = 1'b1;
            r.status        = 1'b1;
            pending_bytes.push_back(r);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                r.out_byte      = enc[i];
                r.byte_position = 16'(int'(model_offset) + i);
                r.last_of_item  = (i == n - 1);
                r.status        = 1'b0;
                pending_bytes.push_back(r);
            end
            model_offset = 17'(int'(model_offset) + n);
        end
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] r;
        int          k;
        r = {$urandom, $urandom};
        k = $urandom_range(0, 63);
        case ($urandom_range(0, 5))
            0: return r;
            1, 2: return r >> $urandom_range(0, 63);
            3: return -(r >> $urandom_range(40, 63));
            4: return (64'd1 << k) - 64'd1;
            default: return ($urandom_range(0, 1) != 0) ? (64'd1 << k) : ~((64'd1 << k) - 64'd1);
        endcase
    endfunction

    function automatic logic [16:0] pick_capacity();
        case ($urandom_range(0, 7))
            0, 1: return zvw_pkg::CAP_ALL_ONES;
            2: return zvw_pkg::RESET_CAPACITY;
            3: return 17'($urandom);
            default: return model_offset + 17'($urandom_range(0, 120));
        endcase
    endfunction

    task automatic send_item(zvw_pkg::action_t act, logic [63:0] value);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.action <= act;
        item_ch.value  <= value;
        do
            @(posedge clk);
        while (!item_ch.ready);
        encode_field(act, value);
        items_sent++;
    endtask

    // Stops the item stream and waits for every predicted byte to come out.
    task automatic drain();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [16:0] cap);
        drain();
        @(negedge clk);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.buffer_capacity <= cap;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        model_capacity = cap;
        cfg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_directed_extremes();
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        send_item(zvw_pkg::ACT_RAW8,  64'hA5A5_A5A5_A5A5_A500);
        send_item(zvw_pkg::ACT_RAW8,  64'h0000_0000_0000_00FF);
        send_item(zvw_pkg::ACT_RAW64, 64'h0123_4567_89AB_CDEF);
        send_item(zvw_pkg::ACT_RAW64, '1);
        send_item(zvw_pkg::ACT_U16,   64'd0);
        send_item(zvw_pkg::ACT_U16,   64'h7F);
        send_item(zvw_pkg::ACT_U16,   64'h80);
        send_item(zvw_pkg::ACT_U16,   64'hFFFF_FFFF_FFFF_FFFF);
        send_item(zvw_pkg::ACT_S16,   64'd0);
        send_item(zvw_pkg::ACT_S16,   64'h0000_0000_0000_FFFF);
        send_item(zvw_pkg::ACT_S16,   64'h0000_0000_0000_7FFF);
        send_item(zvw_pkg::ACT_S16,   64'hFFFF_FFFF_FFFF_8000);
        send_item(zvw_pkg::ACT_U32,   64'h5555_5555_FFFF_FFFF);
        send_item(zvw_pkg::ACT_U32,   64'h0000_0000_1000_0000);
        send_item(zvw_pkg::ACT_S32,   64'h0000_0000_8000_0000);
        send_item(zvw_pkg::ACT_S32,   64'h0000_0000_7FFF_FFFF);
        send_item(zvw_pkg::ACT_U64,   '1);
        send_item(zvw_pkg::ACT_U64,   64'h8000_0000_0000_0000);
        send_item(zvw_pkg::ACT_U64,   64'h0100_0000_0000_0000);
        send_item(zvw_pkg::ACT_S64,   64'h8000_0000_0000_0000);
        send_item(zvw_pkg::ACT_S64,   64'h7FFF_FFFF_FFFF_FFFF);
        send_item(zvw_pkg::ACT_S64,   '1);
        drain();
    endtask

    task automatic test_capacity_limits();
        sender_idle_pct = 0;
        sink_stall_pct  = 45;
        // Three bytes of room: a two-byte varint fits, a three-byte one does
        // not, and a single byte then fills the buffer exactly.
        write_capacity(model_offset + 17'd3);
        send_item(zvw_pkg::ACT_U16, 64'h3FFF);
        send_item(zvw_pkg::ACT_U16, 64'h4000);
        send_item(zvw_pkg::ACT_RAW8, 64'h5A);
        send_item(zvw_pkg::ACT_RAW8, 64'hC3);
        write_capacity(17'd0);
        send_item(zvw_pkg::ACT_U64, '1);
        send_item(zvw_pkg::ACT_RAW64, 64'h1122_3344_5566_7788);
        // Capacity lowered below what is already written.
        write_capacity(model_offset - 17'd1);
        send_item(zvw_pkg::ACT_RAW8, 64'h01);
        write_capacity(model_offset);
        send_item(zvw_pkg::ACT_S16, 64'd1);
        // Capacity above the buffer size is clamped to it.
        write_capacity(zvw_pkg::CAP_ALL_ONES);
        send_item(zvw_pkg::ACT_RAW8, 64'h7E);
        send_item(zvw_pkg::ACT_S64, 64'hFFFF_FFFF_FFFF_FFC0);
        drain();
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 22 == 0)
                write_capacity(pick_capacity());
            send_item(zvw_pkg::action_t'($urandom_range(0, 7)), random_value());
        end
        drain();
    endtask

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        wr_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            bytes_checked++;
            if (result_ch.status)
                no_space_seen++;
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected result: out_byte %h at position %0d",
                       result_ch.out_byte, result_ch.byte_position);
                errors++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (result_ch.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, result_ch.out_byte);
                    errors++;
                end
                if (result_ch.byte_position !== want.byte_position)
                begin
                    $error("byte_position: expected %0d, got %0d",
                           want.byte_position, result_ch.byte_position);
                    errors++;
                end
                if (result_ch.last_of_item !== want.last_of_item)
                begin
                    $error("last_of_item: expected %b, got %b",
                           want.last_of_item, result_ch.last_of_item);
                    errors++;
                end
                if (result_ch.status !== want.status)
                begin
                    $error("status: expected %b, got %b", want.status, result_ch.status);
                    errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout with %0d bytes still owed", pending_bytes.size());
        $display("zigzag_varint_field_writer: mismatch");
        $finish;
    end

    initial
    begin
        item_ch.valid          = 1'b0;
        item_ch.action         = zvw_pkg::ACT_RAW8;
        item_ch.value          = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.buffer_capacity = '0;
        model_capacity         = zvw_pkg::RESET_CAPACITY;
        model_offset           = '0;
        rst_n                  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_extremes();
        test_capacity_limits();
        test_random_traffic(0, 0, 80);
        test_random_traffic(45, 0, 80);
        test_random_traffic(0, 45, 80);
        test_random_traffic(18, 18, 80);

        drain();
        repeat (16) @(posedge clk);
        if (pending_bytes.size() != 0)
        begin
            $error("%0d predicted bytes never arrived", pending_bytes.size());
            errors++;
        end

        $display("Sent %0d items over directed cases and four idle/stall mixes.", items_sent);
        $display("Checked %0d results, %0d of them no-space, after %0d capacity writes.",
                 bytes_checked, no_space_seen, cfg_writes);
        if (errors == 0)
            $display("zigzag_varint_field_writer: match");
        else
            $display("zigzag_varint_field_writer: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
